/* hdl/id3fp_pkg.sv */
// Package for the ID3v2.3 tag frame parser: word types, phase enum,
// status/kind codes, frame id constants and the id-to-kind lookup.
// No dependencies.
package id3fp_pkg;

    // Input word: one file byte plus the restart mark
    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } in_word_t;

    // Result word: one per input byte
    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_valid;
        logic [2:0] field_kind;
        logic       frame_last;
        logic [2:0] status;
    } out_word_t;

    // Parser phase
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_FHDR,
        PH_PAYLOAD,
        PH_DONE,
        PH_NOMAGIC,
        PH_BADSIZE
    } phase_t;

    // Status codes
    localparam logic [2:0] ST_HEADER  = 3'd0;
    localparam logic [2:0] ST_FRAMES  = 3'd1;
    localparam logic [2:0] ST_DONE    = 3'd2;
    localparam logic [2:0] ST_NOMAGIC = 3'd3;
    localparam logic [2:0] ST_BADSIZE = 3'd4;

    // Field kinds
    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_TITLE   = 3'd1;
    localparam logic [2:0] KIND_YEAR    = 3'd2;
    localparam logic [2:0] KIND_ALBUM   = 3'd3;
    localparam logic [2:0] KIND_ARTIST  = 3'd4;
    localparam logic [2:0] KIND_GENRE   = 3'd5;
    localparam logic [2:0] KIND_COMMENT = 3'd6;

    // Frame ids, big-endian ASCII
    localparam logic [31:0] ID_TITLE   = 32'h5449_5432; // TIT2
    localparam logic [31:0] ID_YEAR    = 32'h5459_4552; // TYER
    localparam logic [31:0] ID_ALBUM   = 32'h5441_4C42; // TALB
    localparam logic [31:0] ID_ARTIST  = 32'h5450_4531; // TPE1
    localparam logic [31:0] ID_GENRE   = 32'h5443_4F4E; // TCON
    localparam logic [31:0] ID_COMMENT = 32'h434F_4D4D; // COMM

    // Header magic "ID3"
    localparam logic [7:0] MAGIC_0 = 8'h49;
    localparam logic [7:0] MAGIC_1 = 8'h44;
    localparam logic [7:0] MAGIC_2 = 8'h33;

    // Header byte positions and frame header size
    localparam logic [3:0] HDR_SIZE0   = 4'd6;
    localparam logic [3:0] HDR_LAST    = 4'd9;
    localparam logic [3:0] FH_LEN0     = 4'd4;
    localparam logic [3:0] FH_LEN3     = 4'd7;
    localparam logic [3:0] FH_LAST     = 4'd9;
    localparam int         FRAME_HDR_B = 10;

    // Tag size is 29 bits, with the size bytes ORed in unmasked
    localparam int TAG_W = 29;

    function automatic logic [2:0] kind_of(input logic [31:0] id);
        logic [2:0] k;
        k = KIND_NONE;
        if (id == ID_TITLE)   k = KIND_TITLE;
        if (id == ID_YEAR)    k = KIND_YEAR;
        if (id == ID_ALBUM)   k = KIND_ALBUM;
        if (id == ID_ARTIST)  k = KIND_ARTIST;
        if (id == ID_GENRE)   k = KIND_GENRE;
        if (id == ID_COMMENT) k = KIND_COMMENT;
        return k;
    endfunction

    function automatic logic [7:0] magic_at(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0:    m = MAGIC_0;
            2'd1:    m = MAGIC_1;
            default: m = MAGIC_2;
        endcase
        return m;
    endfunction

endpackage

/* hdl/id3fp_core.sv */
// Parser state registers and the per-byte next-state/result logic.
// Depends on id3fp_pkg.
module id3fp_core
    import id3fp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_fire,
    input  in_word_t  in_word,
    output out_word_t res
);

    phase_t             phase_reg, phase_next;
    logic [3:0]         fc_reg, fc_next;
    logic [TAG_W-1:0]   tl_reg, tl_next;
    logic [TAG_W-1:0]   bd_reg, bd_next;
    logic [31:0]        ident_reg, ident_next;
    logic [31:0]        len_reg, len_next;
    logic [31:0]        pl_reg, pl_next;
    logic [2:0]         kind_reg, kind_next;
    logic               ended_reg, ended_next;

    // State seen by this byte: reset values when file_start is set
    phase_t             cur_phase;
    logic [3:0]         cur_fc;
    logic [TAG_W-1:0]   cur_tl;
    logic [TAG_W-1:0]   cur_bd;
    logic [31:0]        cur_ident;
    logic [31:0]        cur_len;
    logic [31:0]        cur_pl;
    logic [2:0]         cur_kind;
    logic               cur_ended;

    logic [7:0]         d;
    logic [32:0]        frame_end;
    logic [TAG_W:0]     bd_sum;
    logic               first;

    assign d         = in_word.data_byte;
    assign cur_phase = in_word.file_start ? PH_HEADER : phase_reg;
    assign cur_fc    = in_word.file_start ? 4'd0 : fc_reg;
    assign cur_tl    = in_word.file_start ? '0 : tl_reg;
    assign cur_bd    = in_word.file_start ? '0 : bd_reg;
    assign cur_ident = in_word.file_start ? '0 : ident_reg;
    assign cur_len   = in_word.file_start ? '0 : len_reg;
    assign cur_pl    = in_word.file_start ? '0 : pl_reg;
    assign cur_kind  = in_word.file_start ? KIND_NONE : kind_reg;
    assign cur_ended = in_word.file_start ? 1'b0 : ended_reg;

    // End of the frame being sized: bytes so far + header + size that the
    // last size byte completes
    assign frame_end = 33'({4'b0, cur_bd}) + 33'(FRAME_HDR_B) + {1'b0, cur_len[23:0], d};
    // Running byte count at the end of a payload (fits, size was checked)
    assign bd_sum    = (TAG_W+1)'({1'b0, cur_bd}) + (TAG_W+1)'(FRAME_HDR_B)
                     + cur_len[TAG_W:0];
    assign first     = (cur_pl == cur_len);

    // Next state and result for one byte
    always_comb begin
        phase_next = phase_reg;
        fc_next    = fc_reg;
        tl_next    = tl_reg;
        bd_next    = bd_reg;
        ident_next = ident_reg;
        len_next   = len_reg;
        pl_next    = pl_reg;
        kind_next  = kind_reg;
        ended_next = ended_reg;
        res        = '0;
        if (in_fire) begin
            phase_next = cur_phase;
            fc_next    = cur_fc;
            tl_next    = cur_tl;
            bd_next    = cur_bd;
            ident_next = cur_ident;
            len_next   = cur_len;
            pl_next    = cur_pl;
            kind_next  = cur_kind;
            ended_next = cur_ended;
            case (cur_phase)
                PH_HEADER: begin
                    if (cur_fc < 4'd3) begin
                        if (d != magic_at(cur_fc[1:0])) phase_next = PH_NOMAGIC;
                    end else if (cur_fc == HDR_SIZE0) begin
                        tl_next = TAG_W'(d);
                    end else if (cur_fc > HDR_SIZE0) begin
                        // size bytes ORed in unmasked, as the file does
                        tl_next = {cur_tl[TAG_W-8:0], 7'b0} | TAG_W'(d);
                    end
                    if (phase_next == PH_HEADER) begin
                        if (cur_fc >= HDR_LAST) begin
                            fc_next    = 4'd0;
                            bd_next    = '0;
                            phase_next = (tl_next == '0) ? PH_DONE : PH_FHDR;
                        end else begin
                            fc_next = cur_fc + 4'd1;
                        end
                    end
                end
                PH_FHDR: begin
                    if (cur_fc == 4'd0) begin
                        // zero id byte is padding
                        if (d == 8'd0) phase_next = PH_DONE;
                        else           ident_next = {24'b0, d};
                    end else if (cur_fc < FH_LEN0) begin
                        ident_next = {cur_ident[23:0], d};
                    end else if (cur_fc <= FH_LEN3) begin
                        len_next = (cur_fc == FH_LEN0) ? {24'b0, d}
                                                       : {cur_len[23:0], d};
                        if (cur_fc == FH_LEN3) begin
                            if (len_next[31] || len_next == '0 ||
                                frame_end > 33'(cur_tl))
                                phase_next = PH_BADSIZE;
                        end
                    end
                    if (phase_next == PH_FHDR) begin
                        if (cur_fc >= FH_LAST) begin
                            fc_next    = 4'd0;
                            pl_next    = cur_len;
                            kind_next  = kind_of(cur_ident);
                            ended_next = 1'b0;
                            phase_next = PH_PAYLOAD;
                        end else begin
                            fc_next = cur_fc + 4'd1;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (cur_pl != '0) pl_next = cur_pl - 32'd1;
                    res.field_kind = cur_kind;
                    // skip encoding byte; show text up to the first zero
                    if (!first && !cur_ended && cur_kind != KIND_NONE) begin
                        if (d == 8'd0) begin
                            ended_next = 1'b1;
                        end else begin
                            res.text_valid = 1'b1;
                            res.text_byte  = d;
                        end
                    end
                    if (pl_next == '0) begin
                        res.frame_last = 1'b1;
                        bd_next        = bd_sum[TAG_W-1:0];
                        phase_next     = (bd_sum >= {1'b0, cur_tl}) ? PH_DONE : PH_FHDR;
                        fc_next        = 4'd0;
                    end
                end
                default: begin
                end
            endcase
            case (phase_next)
                PH_HEADER:  res.status = ST_HEADER;
                PH_FHDR:    res.status = ST_FRAMES;
                PH_PAYLOAD: res.status = ST_FRAMES;
                PH_DONE:    res.status = ST_DONE;
                PH_NOMAGIC: res.status = ST_NOMAGIC;
                default:    res.status = ST_BADSIZE;
            endcase
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            fc_reg    <= '0;
            tl_reg    <= '0;
            bd_reg    <= '0;
            ident_reg <= '0;
            len_reg   <= '0;
            pl_reg    <= '0;
            kind_reg  <= KIND_NONE;
            ended_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            fc_reg    <= fc_next;
            tl_reg    <= tl_next;
            bd_reg    <= bd_next;
            ident_reg <= ident_next;
            len_reg   <= len_next;
            pl_reg    <= pl_next;
            kind_reg  <= kind_next;
            ended_reg <= ended_next;
        end
    end

    // Byte count never passes the tag size
    a_bd_in_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        bd_reg <= tl_reg)
        else $error("bytes done beyond tag size");

    // Payload phase always has bytes left to take
    a_pl_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> pl_reg != '0)
        else $error("payload phase with no bytes left");

    // Frame counter stays inside a ten-byte header
    a_fc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fc_reg <= HDR_LAST)
        else $error("header byte counter out of range");

endmodule

/* hdl/id3v2_frame_parser_unit.sv */
// Top level of the ID3v2.3 tag frame parser: parser core plus a
// two-entry output buffer (result register and skid register).
// Depends on id3fp_pkg and id3fp_core.
//
//   channel | dir | ports                      | word
//   s_      | in  | s_valid, s_ready, s_data   | in_word_t  (one file byte)
//   m_      | out | m_valid, m_ready, m_data   | out_word_t (one result per byte)
//
// One byte accepted per cycle while s_ready is high; its result is on m_ in the
// cycle after acceptance, or later when it lands in the skid register behind a
// held result word. Throughput is set by the state update in id3fp_core.
// The skid register lets one more byte in while m_ is stalled; s_ready drops
// only while the skid register is full.
// aresetn (synchronous, active low) puts the parser in the header phase and
// empties both output registers.
module id3v2_frame_parser_unit
    import id3fp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic      s_fire, m_fire;
    out_word_t res;
    out_word_t out_reg, skid_reg;
    logic      out_valid_reg, skid_valid_reg;

    assign s_ready = !skid_valid_reg;
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = out_valid_reg && m_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    id3fp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (s_fire),
        .in_word (s_data),
        .res     (res)
    );

    // Output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (m_fire || !out_valid_reg) begin
                if (skid_valid_reg) begin
                    out_reg        <= skid_reg;
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else if (s_fire) begin
                    out_reg       <= res;
                    out_valid_reg <= 1'b1;
                end else begin
                    out_valid_reg <= 1'b0;
                end
            end else if (s_fire) begin
                skid_reg       <= res;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Skid word only exists behind a held result word
    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without result word");

    // An accepted byte always leaves a result behind
    a_accept_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_valid)
        else $error("accepted byte produced no result");

    // Shown text is a nonzero byte of a known text frame
    a_text_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.text_valid |->
            m_data.field_kind != KIND_NONE && m_data.text_byte != 8'd0)
        else $error("text byte outside a text frame");

    // After a frame's last byte the parser is in frames or done
    a_last_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_last |->
            m_data.status == ST_FRAMES || m_data.status == ST_DONE)
        else $error("bad status on last payload byte");

endmodule
